### hw/rtl/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; imported by every module of the block.
package pva_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int COUNT_W    = 16;
  localparam int VEL_W      = 16;
  localparam int OVEL_W     = 15;
  localparam int MASK_W     = 16;
  localparam int VOICE_CAP  = 16;
  localparam int VIDX_W     = 4;
  localparam int VCNT_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_FULL = 16'hFFFF;
  localparam logic [VEL_W-1:0]   VEL_ONE    = 16'd16384;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_ALL_OFF  = 2'd2;
  localparam logic [1:0] OP_RESET    = 2'd3;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_START       = 3'd1;
  localparam logic [2:0] ACT_RELEASE     = 3'd2;
  localparam logic [2:0] ACT_RELEASE_ALL = 3'd3;
  localparam logic [2:0] ACT_RESET_ALL   = 3'd4;

  localparam logic REG_ENGINE_READY = 1'b0;
  localparam logic REG_VOICES       = 1'b1;

  typedef struct packed {
    logic load;  // item beat taken, latch it and read its count
    logic fire;  // decide, update state, load result register
  } pva_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new beat
  } pva_sts_t;

endpackage

### hw/rtl/pva_ctrl.sv
// Controller for the voice allocator: two-state sequencer per event.
// Depends on pva_pkg; drives commands into pva_dpath.
module pva_ctrl
  import pva_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pva_sts_t sts,
  output pva_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && in_valid;
  assign cmd.fire = (state_r == ST_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### hw/rtl/pva_dpath.sv
// Datapath for the voice allocator: count store, voice note lanes,
// config registers, decision logic and result register. Depends on pva_pkg.
module pva_dpath
  import pva_pkg::*;
#(
  parameter int VOICE_N = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pva_cmd_t                 cmd,
  output pva_sts_t                 sts,
  input  logic [1:0]               in_operation,
  input  logic [NOTE_W-1:0]        in_note_number,
  input  logic signed [VEL_W-1:0]  in_velocity_q14,
  input  logic [MASK_W-1:0]        in_active_mask,
  input  logic                     cfg_valid,
  input  logic                     cfg_index,
  input  logic [VCNT_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic [2:0]               out_voice_action,
  output logic [VIDX_W-1:0]        out_target_voice,
  output logic [NOTE_W-1:0]        out_voice_note,
  output logic [OVEL_W-1:0]        out_voice_velocity
);

  // config
  logic              engine_ready_r;
  logic [VCNT_W-1:0] voices_r;

  // latched item
  logic [1:0]        op_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;
  logic [MASK_W-1:0] mask_r;

  // count store
  logic [COUNT_W-1:0]    cnt_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] cnt_vld_r;
  logic [COUNT_W-1:0]    rd_r;
  logic                  rd_vld_r;

  // voice notes
  logic [NOTE_W-1:0] anote_r [VOICE_N];

  // result register
  logic              out_valid_r;
  logic              acc_r;
  logic [2:0]        act_r;
  logic [VIDX_W-1:0] tv_r;
  logic [NOTE_W-1:0] vn_r;
  logic [OVEL_W-1:0] vv_r;

  // decision
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] cnt_dec;
  logic [VCNT_W-1:0]  n_eff;
  logic               hit_any;
  logic [VIDX_W-1:0]  hit_idx;
  logic               free_any;
  logic [VIDX_W-1:0]  free_idx;
  logic               is_off;
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               cnt_clr;
  logic               an_we;
  logic [VIDX_W-1:0]  an_idx;
  logic               acc_nxt;
  logic [2:0]         act_nxt;
  logic [VIDX_W-1:0]  tv_nxt;
  logic [NOTE_W-1:0]  vn_nxt;
  logic [OVEL_W-1:0]  vv_nxt;

  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_accepted       = acc_r;
  assign out_voice_action   = act_r;
  assign out_target_voice   = tv_r;
  assign out_voice_note     = vn_r;
  assign out_voice_velocity = vv_r;

  assign count   = rd_vld_r ? rd_r : '0;
  assign cnt_dec = count - COUNT_W'(1);

  always_comb begin
    if (voices_r == '0) n_eff = VCNT_W'(1);
    else if (voices_r > VCNT_W'(VOICE_N)) n_eff = VCNT_W'(VOICE_N);
    else n_eff = voices_r;
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICE_N - 1; i >= 0; i--) begin
      if (VCNT_W'(i) < n_eff) begin
        if (mask_r[i] && anote_r[i] == note_r) begin
          hit_any = 1'b1;
          hit_idx = VIDX_W'(i);
        end
        if (!mask_r[i]) begin
          free_any = 1'b1;
          free_idx = VIDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    is_off    = (op_r == OP_NOTE_OFF) || (op_r == OP_NOTE_ON && vel_r == '0);
    cnt_we    = 1'b0;
    cnt_wdata = cnt_dec;
    cnt_clr   = 1'b0;
    an_we     = 1'b0;
    an_idx    = '0;
    acc_nxt   = 1'b0;
    act_nxt   = ACT_NONE;
    tv_nxt    = '0;
    vn_nxt    = '0;
    vv_nxt    = '0;
    if (op_r == OP_ALL_OFF) begin
      cnt_clr = 1'b1;
      acc_nxt = 1'b1;
      act_nxt = ACT_RELEASE_ALL;
    end else if (op_r == OP_RESET) begin
      cnt_clr = 1'b1;
      acc_nxt = 1'b1;
      act_nxt = ACT_RESET_ALL;
    end else if (!engine_ready_r) begin
      acc_nxt = 1'b0;
    end else if (is_off) begin
      if (count != '0) begin
        cnt_we  = 1'b1;
        acc_nxt = 1'b1;
        if (cnt_dec == '0 && hit_any) begin
          act_nxt = ACT_RELEASE;
          tv_nxt  = hit_idx;
          vn_nxt  = note_r;
        end
      end
    end else if (!vel_r[VEL_W-1] && count != COUNT_FULL) begin
      cnt_we    = 1'b1;
      cnt_wdata = count + COUNT_W'(1);
      an_we     = 1'b1;
      if (hit_any) an_idx = hit_idx;
      else if (free_any) an_idx = free_idx;
      else an_idx = '0;
      acc_nxt = 1'b1;
      act_nxt = ACT_START;
      tv_nxt  = an_idx;
      vn_nxt  = note_r;
      vv_nxt  = (vel_r > VEL_ONE) ? VEL_ONE[OVEL_W-1:0] : vel_r[OVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engine_ready_r <= 1'b0;
      voices_r       <= VCNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ENGINE_READY) engine_ready_r <= cfg_data[0];
      else voices_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      note_r <= in_note_number;
      vel_r  <= in_velocity_q14;
      mask_r <= in_active_mask;
      rd_r   <= cnt_mem[in_note_number];
    end
    if (cmd.fire && cnt_we) cnt_mem[note_r] <= cnt_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.load) rd_vld_r <= cnt_vld_r[in_note_number];
      if (cmd.fire && cnt_clr) cnt_vld_r <= '0;
      else if (cmd.fire && cnt_we) cnt_vld_r[note_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VOICE_N; i++) begin
      if (!rst_n) anote_r[i] <= '0;
      else if (cmd.fire && an_we && an_idx == VIDX_W'(i)) anote_r[i] <= note_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.fire) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      acc_r <= acc_nxt;
      act_r <= act_nxt;
      tv_r  <= tv_nxt;
      vn_r  <= vn_nxt;
      vv_r  <= vv_nxt;
    end
  end

endmodule

### hw/rtl/poly_voice_allocator.sv
// Polyphonic voice allocator, top level. An input beat is latched in the idle
// state; its result beat is loaded in the exec state once the result register
// is free. The input stalls until then, as the registered read of the note
// count store is followed by its write-back; a stalled result holds the input.
// Reset (rst_n, synchronous) clears all counts through per-note valid bits,
// with no clearing pass; voice notes clear to 0, engine off, one voice.
// Depends on pva_pkg, pva_ctrl and pva_dpath.
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int MAX_VOICES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [NOTE_W-1:0]        in_note_number,
  input  logic signed [VEL_W-1:0]  in_velocity_q14,
  input  logic [MASK_W-1:0]        in_active_mask,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic [2:0]               out_voice_action,
  output logic [VIDX_W-1:0]        out_target_voice,
  output logic [NOTE_W-1:0]        out_voice_note,
  output logic [OVEL_W-1:0]        out_voice_velocity,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [VCNT_W-1:0]        cfg_data
);

  localparam int VOICE_N = (MAX_VOICES < VOICE_CAP) ? MAX_VOICES : VOICE_CAP;

  pva_cmd_t cmd;
  pva_sts_t sts;

  assign cfg_ready = 1'b1;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pva_dpath #(
    .VOICE_N (VOICE_N)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_note_number     (in_note_number),
    .in_velocity_q14    (in_velocity_q14),
    .in_active_mask     (in_active_mask),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_voice_action   (out_voice_action),
    .out_target_voice   (out_target_voice),
    .out_voice_note     (out_voice_note),
    .out_voice_velocity (out_voice_velocity)
  );

endmodule
